// ===== src/hctb_pkg.sv =====
// Shared types and constants for the Huffman code tree builder.
// Holds field widths, kind and status codes, and the control/status
// structs between controller and datapath. No dependencies.
package hctb_pkg;

  // Default sizes
  localparam int unsigned MAX_WORDS_DEF = 1024;
  localparam int unsigned MAX_CODE_DEF  = 40;

  // Port field widths
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CNT_W   = 50;
  localparam int unsigned WORD_W  = 10;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned NODE_W  = 10;
  localparam int unsigned DEPTH_W = 6;

  // Saturation limit of a merged count
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD  = 2'd0,
    KIND_BUILD = 2'd1,
    KIND_QUERY = 2'd2
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_BAD  = 2'd1,
    STAT_LONG = 2'd2,
    STAT_FULL = 2'd3
  } status_e;

  // Controller -> datapath commands
  typedef struct packed {
    logic    capture;    // latch input word
    logic    ld_write;   // store count, bump word count
    logic    bld_init;   // set up both queues
    logic    bld_read;   // read heads of leaf and merged queues
    logic    take1;      // take first child of a merge
    logic    take2;      // take second child of a merge
    logic    bld_sum;    // write merged count
    logic    q_init;     // start a path walk at the leaf
    logic    q_read;     // read parent link of current node
    logic    q_push;     // push one level onto the path stack
    logic    s_read;     // read next level from the path stack
    logic    emit_stat;  // send a single status word
    logic    emit_lvl;   // send one path level
    status_e stat;       // status code for emit_stat
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    kind_e kind;        // captured kind
    logic  full;        // word store full
    logic  few;         // fewer than two words
    logic  q_ok;        // tree built and word in range
    logic  node_avail;  // some queue still holds a node
    logic  build_done;  // current merge writes the root
    logic  at_root;     // parent just read is the root
    logic  len_last;    // walk reached the code length limit
    logic  lvl_last;    // level in the read buffer is the leaf level
    logic  out_free;    // output register can take a word
  } sts_t;

endpackage

// ===== src/hctb_ctrl.sv =====
// Controller state machine of the Huffman code tree builder.
// Sequences loads, the two-queue merge and the code path walk.
// Depends on hctb_pkg for cmd_t, sts_t and the code enums.
module hctb_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  hctb_pkg::sts_t sts_i,
  output hctb_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_EMIT,
    ST_B_RD1,
    ST_B_TK1,
    ST_B_RD2,
    ST_B_TK2,
    ST_B_SUM,
    ST_Q_RD,
    ST_Q_CHK,
    ST_S_RD,
    ST_S_OUT
  } state_e;

  state_e               state_q, state_d;
  hctb_pkg::status_e    stat_q, stat_d;

  assign in_ready_o = (state_q == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    stat_d      = stat_q;
    cmd_o       = '0;
    cmd_o.stat  = stat_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (sts_i.kind)
          hctb_pkg::KIND_LOAD: begin
            if (sts_i.full) begin
              stat_d = hctb_pkg::STAT_FULL;
            end else begin
              cmd_o.ld_write = 1'b1;
              stat_d         = hctb_pkg::STAT_OK;
            end
            state_d = ST_EMIT;
          end
          hctb_pkg::KIND_BUILD: begin
            if (sts_i.few) begin
              stat_d  = hctb_pkg::STAT_BAD;
              state_d = ST_EMIT;
            end else begin
              cmd_o.bld_init = 1'b1;
              state_d        = ST_B_RD1;
            end
          end
          hctb_pkg::KIND_QUERY: begin
            if (sts_i.q_ok) begin
              cmd_o.q_init = 1'b1;
              state_d      = ST_Q_RD;
            end else begin
              stat_d  = hctb_pkg::STAT_BAD;
              state_d = ST_EMIT;
            end
          end
          default: begin
            stat_d  = hctb_pkg::STAT_BAD;
            state_d = ST_EMIT;
          end
        endcase
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_stat = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      // one merge: read, take, read, take, sum
      ST_B_RD1: begin
        cmd_o.bld_read = 1'b1;
        state_d        = ST_B_TK1;
      end
      ST_B_TK1: begin
        cmd_o.take1 = 1'b1;
        state_d     = ST_B_RD2;
      end
      ST_B_RD2: begin
        cmd_o.bld_read = 1'b1;
        state_d        = ST_B_TK2;
      end
      ST_B_TK2: begin
        cmd_o.take2 = 1'b1;
        state_d     = ST_B_SUM;
      end
      ST_B_SUM: begin
        cmd_o.bld_sum = 1'b1;
        if (sts_i.build_done) begin
          stat_d  = hctb_pkg::STAT_OK;
          state_d = ST_EMIT;
        end else begin
          state_d = ST_B_RD1;
        end
      end
      // walk leaf to root, stacking levels
      ST_Q_RD: begin
        cmd_o.q_read = 1'b1;
        state_d      = ST_Q_CHK;
      end
      ST_Q_CHK: begin
        cmd_o.q_push = 1'b1;
        priority if (sts_i.at_root) begin
          state_d = ST_S_RD;
        end else if (sts_i.len_last) begin
          stat_d  = hctb_pkg::STAT_LONG;
          state_d = ST_EMIT;
        end else begin
          state_d = ST_Q_RD;
        end
      end
      // replay the stack root first
      ST_S_RD: begin
        cmd_o.s_read = 1'b1;
        state_d      = ST_S_OUT;
      end
      ST_S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_lvl = 1'b1;
          state_d        = sts_i.lvl_last ? ST_IDLE : ST_S_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered status code
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      stat_q  <= hctb_pkg::STAT_OK;
    end else begin
      state_q <= state_d;
      stat_q  <= stat_d;
    end
  end

`ifndef SYNTHESIS
  // a take always finds a node in one of the queues
  a_take_has_node: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_B_TK1 || state_q == ST_B_TK2) |-> sts_i.node_avail)
    else $error("merge take with both queues empty");

  // an accepted word is decoded in the next cycle
  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_DECODE))
    else $error("accepted word not decoded");
`endif

endmodule

// ===== src/hctb_dp.sv =====
// Datapath of the Huffman code tree builder: count, link and path
// stack memories, queue pointers, merge adder and output register.
// Depends on hctb_pkg; driven by hctb_ctrl through cmd_t.
module hctb_dp #(
  parameter int unsigned MAX_WORDS = hctb_pkg::MAX_WORDS_DEF,
  parameter int unsigned MAX_CODE  = hctb_pkg::MAX_CODE_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [hctb_pkg::KIND_W-1:0]    kind_i,
  input  logic [hctb_pkg::CNT_W-1:0]     count_value_i,
  input  logic [hctb_pkg::WORD_W-1:0]    word_index_i,
  input  hctb_pkg::cmd_t                 cmd_i,
  output hctb_pkg::sts_t                 sts_o,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [hctb_pkg::STAT_W-1:0]    status_o,
  output logic                           code_bit_o,
  output logic [hctb_pkg::NODE_W-1:0]    node_index_o,
  output logic [hctb_pkg::DEPTH_W-1:0]   depth_o,
  output logic                           last_o
);

  localparam int unsigned CNT_W   = hctb_pkg::CNT_W;
  localparam int unsigned WORD_W  = hctb_pkg::WORD_W;
  localparam int unsigned NODE_W  = hctb_pkg::NODE_W;
  localparam int unsigned DEPTH_W = hctb_pkg::DEPTH_W;
  localparam int unsigned SLOTS   = 2 * MAX_WORDS;
  localparam int unsigned AW      = $clog2(SLOTS);
  localparam int unsigned WLW     = $clog2(MAX_WORDS + 1);
  localparam int unsigned LW      = $clog2(MAX_CODE + 1);
  localparam int unsigned SAW     = $clog2(MAX_CODE);
  localparam int unsigned SDW     = NODE_W + 1;

  // Memories
  logic [CNT_W-1:0] cnt_mem  [SLOTS];
  logic [AW:0]      link_mem [SLOTS];   // {branch, parent slot}
  logic [SDW-1:0]   stk_mem  [MAX_CODE]; // {code bit, node index}

  // Captured input word
  hctb_pkg::kind_e   kind_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [WORD_W-1:0] w_q;

  // Control registers
  logic [WLW-1:0] wl_q;
  logic           built_q;
  logic [WLW-1:0] lq_n_q;   // leaves left in leaf queue
  logic [AW-1:0]  mq_q;     // head of merged queue
  logic [AW-1:0]  slot_q;   // slot of the node being formed
  logic [LW-1:0]  len_q;
  logic [LW-1:0]  d_q;
  logic           out_valid_q;

  // Datapath registers
  logic [CNT_W-1:0] rd_a_q, rd_b_q, c1_q, c2_q;
  logic [AW:0]      link_q;
  logic [AW-1:0]    b_q;
  logic [SDW-1:0]   stk_rd_q;
  logic [hctb_pkg::STAT_W-1:0]  status_q;
  logic                         bit_q;
  logic [NODE_W-1:0]            node_q;
  logic [DEPTH_W-1:0]           depth_q;
  logic                         last_q;

  // Width adaptation
  logic [AW+WLW-1:0]     wl_pad, lq_pad;
  logic [AW+WORD_W-1:0]  w_pad;
  logic [WLW+WORD_W-1:0] cmp_w, cmp_v;
  logic [AW+NODE_W-1:0]  node_pad;
  logic [LW+DEPTH_W-1:0] d_pad;
  logic [AW-1:0]         v_a, lq_a, w_a, root_a, link_par, diff;
  logic                  link_bit;
  logic [NODE_W-1:0]     node_v;
  logic [DEPTH_W-1:0]    depth_v;
  logic [LW-1:0]         stk_idx;
  logic [SAW-1:0]        stk_ra;

  // Merge selection
  logic                  take_leaf;
  logic [AW-1:0]         m_sel;
  logic [CNT_W-1:0]      c_sel, sum_sat;
  logic [CNT_W:0]        sum_w;
  logic                  lvl_last;
  logic                  out_free;

  // Address and index arithmetic
  always_comb begin
    wl_pad   = {{AW{1'b0}}, wl_q};
    v_a      = wl_pad[AW-1:0];
    lq_pad   = {{AW{1'b0}}, lq_n_q};
    lq_a     = lq_pad[AW-1:0] - AW'(1);
    w_pad    = {{AW{1'b0}}, w_q};
    w_a      = w_pad[AW-1:0];
    root_a   = {v_a[AW-2:0], 1'b0} - AW'(2);
    cmp_w    = {{WLW{1'b0}}, w_q};
    cmp_v    = {{WORD_W{1'b0}}, wl_q};
    link_par = link_q[AW-1:0];
    link_bit = link_q[AW];
    diff     = link_par - v_a;
    node_pad = {{NODE_W{1'b0}}, diff};
    node_v   = node_pad[NODE_W-1:0];
    d_pad    = {{DEPTH_W{1'b0}}, d_q};
    depth_v  = d_pad[DEPTH_W-1:0];
    stk_idx  = len_q - d_q - LW'(1);
    stk_ra   = stk_idx[SAW-1:0];
    lvl_last = (d_q == (len_q - LW'(1)));
  end

  // Two-queue pick: merged node wins ties, leaf taken if merged queue empty
  always_comb begin
    take_leaf = (lq_n_q != '0) && ((mq_q == slot_q) || (rd_a_q < rd_b_q));
    m_sel     = take_leaf ? lq_a : mq_q;
    c_sel     = take_leaf ? rd_a_q : rd_b_q;
    sum_w     = {1'b0, c1_q} + {1'b0, c2_q};
    sum_sat   = sum_w[CNT_W] ? hctb_pkg::CNT_MAX : sum_w[CNT_W-1:0];
  end

  assign out_free = !out_valid_q || out_ready_i;

  // Status to controller
  always_comb begin
    sts_o            = '0;
    sts_o.kind       = kind_q;
    sts_o.full       = (wl_q == WLW'(MAX_WORDS));
    sts_o.few        = (wl_q < WLW'(2));
    sts_o.q_ok       = built_q && (cmp_w < cmp_v);
    sts_o.node_avail = (lq_n_q != '0) || (mq_q != slot_q);
    sts_o.build_done = (slot_q == root_a);
    sts_o.at_root    = (link_par == root_a);
    sts_o.len_last   = (len_q == LW'(MAX_CODE - 1));
    sts_o.lvl_last   = lvl_last;
    sts_o.out_free   = out_free;
  end

  // Count memory: one write port, two registered reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_write) begin
      cnt_mem[v_a] <= cnt_q;
    end else if (cmd_i.bld_sum) begin
      cnt_mem[slot_q] <= sum_sat;
    end
    if (cmd_i.bld_read) begin
      rd_a_q <= cnt_mem[lq_a];
      rd_b_q <= cnt_mem[mq_q];
    end
  end

  // Parent/branch memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.take1 || cmd_i.take2) begin
      link_mem[m_sel] <= {cmd_i.take2, slot_q};
    end
    if (cmd_i.q_read) begin
      link_q <= link_mem[b_q];
    end
  end

  // Path stack, filled leaf first and read back root first
  always_ff @(posedge clk_i) begin
    if (cmd_i.q_push) begin
      stk_mem[len_q[SAW-1:0]] <= {link_bit, node_v};
    end
    if (cmd_i.s_read) begin
      stk_rd_q <= stk_mem[stk_ra];
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q        <= '0;
      built_q     <= 1'b0;
      lq_n_q      <= '0;
      mq_q        <= '0;
      slot_q      <= '0;
      len_q       <= '0;
      d_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.ld_write) begin
        wl_q    <= wl_q + WLW'(1);
        built_q <= 1'b0;
      end
      if (cmd_i.bld_sum && sts_o.build_done) begin
        built_q <= 1'b1;
      end
      if (cmd_i.bld_init) begin
        lq_n_q <= wl_q;
        mq_q   <= v_a;
        slot_q <= v_a;
      end
      if (cmd_i.take1 || cmd_i.take2) begin
        if (take_leaf) begin
          lq_n_q <= lq_n_q - WLW'(1);
        end else begin
          mq_q <= mq_q + AW'(1);
        end
      end
      if (cmd_i.bld_sum) begin
        slot_q <= slot_q + AW'(1);
      end
      if (cmd_i.q_init) begin
        len_q <= '0;
        d_q   <= '0;
      end
      if (cmd_i.q_push) begin
        len_q <= len_q + LW'(1);
      end
      if (cmd_i.emit_lvl) begin
        d_q <= d_q + LW'(1);
      end
      if (cmd_i.emit_stat || cmd_i.emit_lvl) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= hctb_pkg::kind_e'(kind_i);
      cnt_q  <= count_value_i;
      w_q    <= word_index_i;
    end
    if (cmd_i.take1) begin
      c1_q <= c_sel;
    end
    if (cmd_i.take2) begin
      c2_q <= c_sel;
    end
    if (cmd_i.q_init) begin
      b_q <= w_a;
    end else if (cmd_i.q_push) begin
      b_q <= link_par;
    end
    if (cmd_i.emit_stat) begin
      status_q <= cmd_i.stat;
      bit_q    <= 1'b0;
      node_q   <= '0;
      depth_q  <= '0;
      last_q   <= 1'b1;
    end else if (cmd_i.emit_lvl) begin
      status_q <= hctb_pkg::STAT_OK;
      bit_q    <= stk_rd_q[NODE_W];
      node_q   <= stk_rd_q[NODE_W-1:0];
      depth_q  <= depth_v;
      last_q   <= lvl_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign code_bit_o   = bit_q;
  assign node_index_o = node_q;
  assign depth_o      = depth_q;
  assign last_o       = last_q;

`ifndef SYNTHESIS
  // word count never passes the store size
  a_wl_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wl_q <= WLW'(MAX_WORDS))
    else $error("word count beyond store size");

  // a built tree always has at least two leaves
  a_built_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    built_q |-> (wl_q >= WLW'(2)))
    else $error("tree marked built with fewer than two words");

  // path stack never overflows
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LW'(MAX_CODE))
    else $error("path stack overflow");
`endif

endmodule

// ===== src/huffman_code_tree_builder_top.sv =====
// Top level of the Huffman code tree builder.
// Joins hctb_ctrl (sequencer) and hctb_dp (memories, queues, output).
// Depends on hctb_pkg, hctb_ctrl and hctb_dp.
//
//   channel  handshake               payload
//   in       in_valid_i / in_ready_o kind_i, count_value_i, word_index_i
//   out      out_valid_o/ out_ready_i status_o, code_bit_o, node_index_o,
//                                    depth_o, last_o
//
// One word is worked on at a time; in_ready_o is high only when idle.
// In a build, each take needs a fresh registered read of both queue heads
// (read, take, read, take, sum). A query walks from leaf to root, pushing
// each level onto the path stack, then sends the levels back root first.
// Output register lets the next word be taken while a result waits; the
// sequencer holds when it has a result and the register is still full.
// Reset clears control only; node memories need no clearing pass.
module huffman_code_tree_builder_top #(
  parameter int unsigned MAX_WORDS = hctb_pkg::MAX_WORDS_DEF,
  parameter int unsigned MAX_CODE  = hctb_pkg::MAX_CODE_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [hctb_pkg::KIND_W-1:0]   kind_i,
  input  logic [hctb_pkg::CNT_W-1:0]    count_value_i,
  input  logic [hctb_pkg::WORD_W-1:0]   word_index_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [hctb_pkg::STAT_W-1:0]   status_o,
  output logic                          code_bit_o,
  output logic [hctb_pkg::NODE_W-1:0]   node_index_o,
  output logic [hctb_pkg::DEPTH_W-1:0]  depth_o,
  output logic                          last_o
);

  hctb_pkg::cmd_t cmd;
  hctb_pkg::sts_t sts;

  // Sequencer
  hctb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Storage and arithmetic
  hctb_dp #(
    .MAX_WORDS (MAX_WORDS),
    .MAX_CODE  (MAX_CODE)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .kind_i        (kind_i),
    .count_value_i (count_value_i),
    .word_index_i  (word_index_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .status_o      (status_o),
    .code_bit_o    (code_bit_o),
    .node_index_o  (node_index_o),
    .depth_o       (depth_o),
    .last_o        (last_o)
  );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for huffman_code_tree_builder_top: drives load, build
// and query words, predicts every result word and compares them in order.
// Depends on hctb_pkg and the top-level RTL only.
module tb_top;

  localparam int unsigned KIND_W       = hctb_pkg::KIND_W;
  localparam int unsigned CNT_W        = hctb_pkg::CNT_W;
  localparam int unsigned WORD_W       = hctb_pkg::WORD_W;
  localparam int unsigned STAT_W       = hctb_pkg::STAT_W;
  localparam int unsigned NODE_W       = hctb_pkg::NODE_W;
  localparam int unsigned DEPTH_W      = hctb_pkg::DEPTH_W;
  localparam logic [CNT_W-1:0] CNT_MAX = hctb_pkg::CNT_MAX;
  localparam int unsigned WORDS_MAX    = hctb_pkg::MAX_WORDS_DEF;
  localparam int unsigned CODE_MAX     = hctb_pkg::MAX_CODE_DEF;
  localparam int unsigned SLOTS        = 2 * WORDS_MAX;
  localparam logic [CNT_W-1:0] FILLER  = 50'd1000000000000000;
  localparam logic [KIND_W-1:0] KIND_ILLEGAL = 2'd3;
  localparam int unsigned RANDOM_WORDS = 415;
  localparam int unsigned TAIL_CYCLES  = 100;
  localparam int unsigned LIMIT_CYCLES = 3000000;

  typedef struct packed {
    hctb_pkg::status_e   st;
    logic                code_bit;
    logic [NODE_W-1:0]   node;
    logic [DEPTH_W-1:0]  depth;
    logic                last;
  } code_word_t;

  // Tree predictor and in-order result checker
  class code_scoreboard;
    logic [CNT_W-1:0] weight [SLOTS];
    logic [10:0]      parent [SLOTS];
    logic             branch [SLOTS];
    int unsigned      n_words;
    bit               built;
    int               leaf_head;
    int               merge_head;
    code_word_t       expected_q[$];
    int unsigned      errors, n_inputs, n_checked, n_builds, n_long, n_full, n_bad;
    int unsigned      n_saturated, deepest;

    task report(string msg);
      errors++;
      if (errors <= 40) $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    function void push_word(hctb_pkg::status_e st, logic cb, logic [NODE_W-1:0] nd,
                            logic [DEPTH_W-1:0] dp, logic lst);
      code_word_t w;
      w.st = st;
      w.code_bit = cb;
      w.node = nd;
      w.depth = dp;
      w.last = lst;
      expected_q.push_back(w);
    endfunction

    // Lighter queue head wins; a tie goes to the merged queue
    function int take_node(int made_end);
      int r;
      if (leaf_head >= 0 &&
          (merge_head >= made_end || weight[leaf_head] < weight[merge_head])) begin
        r = leaf_head;
        leaf_head--;
      end else begin
        r = merge_head;
        merge_head++;
      end
      return r;
    endfunction

    function void build_tree();
      int v, a, slot, m1, m2;
      logic [CNT_W:0] total;
      v = n_words;
      for (a = v; a < 2 * v; a++) weight[a] = FILLER;
      leaf_head = v - 1;
      merge_head = v;
      for (a = 0; a < v - 1; a++) begin
        slot = v + a;
        m1 = take_node(slot);
        m2 = take_node(slot);
        total = {1'b0, weight[m1]} + {1'b0, weight[m2]};
        if (total > {1'b0, CNT_MAX}) begin
          total = {1'b0, CNT_MAX};
          n_saturated++;
        end
        weight[slot] = total[CNT_W-1:0];
        parent[m1] = 11'(slot);
        parent[m2] = 11'(slot);
        branch[m1] = 1'b0;
        branch[m2] = 1'b1;
      end
      built = 1'b1;
    endfunction

    function void note_input(logic [KIND_W-1:0] kind, logic [CNT_W-1:0] cnt,
                             logic [WORD_W-1:0] w);
      int unsigned root, b, p, len, d, e;
      logic        hop_bit [CODE_MAX];
      int unsigned hop_node [CODE_MAX];
      bit          reached;
      n_inputs++;
      case (kind)
        hctb_pkg::KIND_LOAD: begin
          if (n_words >= WORDS_MAX) begin
            push_word(hctb_pkg::STAT_FULL, 1'b0, '0, '0, 1'b1);
            n_full++;
          end else begin
            weight[n_words] = cnt;
            n_words++;
            built = 1'b0;
            push_word(hctb_pkg::STAT_OK, 1'b0, '0, '0, 1'b1);
          end
        end
        hctb_pkg::KIND_BUILD: begin
          if (n_words < 2) begin
            push_word(hctb_pkg::STAT_BAD, 1'b0, '0, '0, 1'b1);
            n_bad++;
          end else begin
            build_tree();
            n_builds++;
            push_word(hctb_pkg::STAT_OK, 1'b0, '0, '0, 1'b1);
          end
        end
        hctb_pkg::KIND_QUERY: begin
          if (built && w < n_words) begin
            // climb from the leaf, then emit levels root first
            root = 2 * n_words - 2;
            b = w;
            len = 0;
            reached = 1'b0;
            while (len < CODE_MAX && !reached) begin
              p = parent[b];
              hop_bit[len] = branch[b];
              hop_node[len] = p;
              len++;
              if (p == root) reached = 1'b1;
              else b = p;
            end
            if (!reached) begin
              push_word(hctb_pkg::STAT_LONG, 1'b0, '0, '0, 1'b1);
              n_long++;
            end else begin
              if (len > deepest) deepest = len;
              for (d = 0; d < len; d++) begin
                e = len - 1 - d;
                push_word(hctb_pkg::STAT_OK, hop_bit[e],
                          NODE_W'(hop_node[e] - n_words), DEPTH_W'(d), d == len - 1);
              end
            end
          end else begin
            push_word(hctb_pkg::STAT_BAD, 1'b0, '0, '0, 1'b1);
            n_bad++;
          end
        end
        default: begin
          push_word(hctb_pkg::STAT_BAD, 1'b0, '0, '0, 1'b1);
          n_bad++;
        end
      endcase
    endfunction

    task check_result(logic [STAT_W-1:0] st, logic cb, logic [NODE_W-1:0] nd,
                      logic [DEPTH_W-1:0] dp, logic lst);
      code_word_t want;
      n_checked++;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result word: status %0d depth %0d", st, dp));
      end else begin
        want = expected_q.pop_front();
        if (st !== want.st)
          report($sformatf("status %0d, want %0d", st, want.st));
        if (cb !== want.code_bit)
          report($sformatf("code_bit %0d, want %0d (depth %0d)", cb, want.code_bit, want.depth));
        if (nd !== want.node)
          report($sformatf("node_index %0d, want %0d (depth %0d)", nd, want.node, want.depth));
        if (dp !== want.depth)
          report($sformatf("depth %0d, want %0d", dp, want.depth));
        if (lst !== want.last)
          report($sformatf("last %0d, want %0d (depth %0d)", lst, want.last, want.depth));
      end
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [KIND_W-1:0]   kind_i;
  logic [CNT_W-1:0]    count_value_i;
  logic [WORD_W-1:0]   word_index_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [STAT_W-1:0]   status_o;
  logic                code_bit_o;
  logic [NODE_W-1:0]   node_index_o;
  logic [DEPTH_W-1:0]  depth_o;
  logic                last_o;

  code_scoreboard sb;
  bit             steady;
  int unsigned    n_sent;

  huffman_code_tree_builder_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .count_value_i (count_value_i),
    .word_index_i  (word_index_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .code_bit_o    (code_bit_o),
    .node_index_o  (node_index_o),
    .depth_o       (depth_o),
    .last_o        (last_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Receiver: random stalls, none during the steady stretch
  always @(negedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(0, 99) >= 31);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(status_o, code_bit_o, node_index_o, depth_o, last_o);
  end

  // Count spread over all magnitudes, with zero and full scale frequent
  function automatic logic [CNT_W-1:0] rand_count();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    case ($urandom_range(0, 7))
      0: return '0;
      1: return CNT_MAX;
      default: return r[CNT_W-1:0] >> $urandom_range(0, CNT_W - 1);
    endcase
  endfunction

  // Send one word; called and returns at a falling edge
  task automatic send_word(logic [KIND_W-1:0] kind, logic [CNT_W-1:0] cnt,
                           logic [WORD_W-1:0] w);
    while (!steady && $urandom_range(0, 99) < 31) begin
      in_valid_i <= 1'b0;
      kind_i <= 2'($urandom_range(0, 3));
      count_value_i <= rand_count();
      word_index_i <= WORD_W'($urandom_range(0, 1023));
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    count_value_i <= cnt;
    word_index_i <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_input(kind, cnt, w);
    n_sent++;
    @(negedge clk_i);
  endtask

  // Hold off the sender until every expected result word has come
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (sb.expected_q.size() != 0) @(negedge clk_i);
  endtask

  // Run of loads, mostly non-increasing with ties; zero runs build long chains
  task automatic load_run(int unsigned n, bit zeros);
    logic [CNT_W-1:0] cur;
    logic [63:0]      r;
    logic [63:0]      span;
    int unsigned      i;
    cur = zeros ? '0 : rand_count();
    for (i = 0; i < n && sb.n_words < WORDS_MAX; i++) begin
      send_word(hctb_pkg::KIND_LOAD, cur, WORD_W'($urandom_range(0, 1023)));
      if (!zeros) begin
        r = {$urandom(), $urandom()};
        span = ({14'b0, cur} >> $urandom_range(0, 6)) + 64'd1;
        if ($urandom_range(0, 3) != 0) cur = cur - CNT_W'(r % span);
        if ($urandom_range(0, 19) == 0) cur = rand_count();  // out-of-order count
      end
    end
  endtask

  // Queries: the last-loaded words sit deepest, so they are favored
  task automatic ask_codes(int unsigned n);
    int unsigned       i, top;
    logic [WORD_W-1:0] w;
    for (i = 0; i < n; i++) begin
      top = (sb.n_words == 0) ? 0 : sb.n_words - 1;
      case ($urandom_range(0, 5))
        0, 1: w = WORD_W'($urandom_range(0, top));
        2, 3, 4: w = WORD_W'(top - $urandom_range(0, (top < 4) ? top : 4));
        default: w = WORD_W'($urandom_range(0, 1023));
      endcase
      send_word(hctb_pkg::KIND_QUERY, rand_count(), w);
    end
  endtask

  initial begin
    int unsigned i, stop_at;
    bit          first;
    sb = new();
    steady = 1'b0;
    n_sent = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    kind_i = hctb_pkg::KIND_LOAD;
    count_value_i = '0;
    word_index_i = '0;
    out_ready_i = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: errors on an empty store, saturating merge, ties on zeros
    send_word(hctb_pkg::KIND_QUERY, '0, '0);
    send_word(hctb_pkg::KIND_BUILD, '0, '0);
    send_word(KIND_ILLEGAL, CNT_MAX, '1);
    send_word(hctb_pkg::KIND_LOAD, CNT_MAX, '0);
    send_word(hctb_pkg::KIND_BUILD, '0, '0);
    send_word(hctb_pkg::KIND_QUERY, '0, '0);
    send_word(hctb_pkg::KIND_LOAD, CNT_MAX, '1);
    send_word(hctb_pkg::KIND_BUILD, CNT_MAX, '1);
    send_word(hctb_pkg::KIND_QUERY, '0, 10'd0);
    send_word(hctb_pkg::KIND_QUERY, CNT_MAX, 10'd1);
    send_word(hctb_pkg::KIND_QUERY, '0, 10'd2);
    send_word(hctb_pkg::KIND_QUERY, '0, '1);
    send_word(hctb_pkg::KIND_LOAD, '0, '0);
    send_word(hctb_pkg::KIND_QUERY, '0, '0);
    send_word(hctb_pkg::KIND_LOAD, '0, '0);
    send_word(hctb_pkg::KIND_LOAD, '0, '0);
    send_word(hctb_pkg::KIND_BUILD, '0, '0);
    for (i = 0; i < 5; i++) send_word(hctb_pkg::KIND_QUERY, '0, WORD_W'(i));
    wait_drained();

    // Random: load runs, build, queries, some noise; first run is all zeros
    stop_at = n_sent + RANDOM_WORDS;
    first = 1'b1;
    while (n_sent < stop_at) begin
      steady = (n_sent > stop_at - 330) && (n_sent < stop_at - 200);
      if (first || $urandom_range(0, 99) < 12) load_run($urandom_range(38, 46), 1'b1);
      else load_run($urandom_range(1, 10), 1'b0);
      first = 1'b0;
      if ($urandom_range(0, 7) != 0)
        send_word(hctb_pkg::KIND_BUILD, rand_count(), WORD_W'($urandom_range(0, 1023)));
      if ($urandom_range(0, 9) == 0)
        send_word(hctb_pkg::KIND_BUILD, rand_count(), WORD_W'($urandom_range(0, 1023)));
      ask_codes($urandom_range(1, 6));
      if ($urandom_range(0, 9) == 0)
        send_word(KIND_ILLEGAL, rand_count(), WORD_W'($urandom_range(0, 1023)));
      if ($urandom_range(0, 11) == 0) wait_drained();
    end
    steady = 1'b0;

    // Closing: build the whole store once more and ask for codes
    send_word(hctb_pkg::KIND_BUILD, '0, '0);
    ask_codes(12);
    send_word(hctb_pkg::KIND_QUERY, '0, '1);
    send_word(hctb_pkg::KIND_BUILD, CNT_MAX, '1);
    ask_codes(6);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d expected words never came", sb.expected_q.size()));

    $display("Run: %0d input words, %0d result words, %0d tree builds, %0d words stored.",
             sb.n_inputs, sb.n_checked, sb.n_builds, sb.n_words);
    $display("Seen: %0d too-long codes, %0d full-store loads, %0d rejects, %0d %s %0d.",
             sb.n_long, sb.n_full, sb.n_bad, sb.n_saturated,
             "saturated merges, deepest code", sb.deepest);
    if (sb.errors == 0) begin
      $display("huffman_code_tree_builder_top verification clean");
    end else begin
      $display("huffman_code_tree_builder_top verification failed");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #(LIMIT_CYCLES * 10);
    $display("huffman_code_tree_builder_top verification failed");
    $finish;
  end

endmodule
